[src/cstp_pkg.sv]
// Shared types, codes and helpers for the call site target profiler.
// Depends on nothing; the profiler and the store use it by scoped names.
`default_nettype none

package cstp_pkg;

   // result status codes
   localparam logic [1:0] ST_FOUND    = 2'd0;
   localparam logic [1:0] ST_INSERTED = 2'd1;
   localparam logic [1:0] ST_DROPPED  = 2'd2;
   localparam logic [1:0] ST_IGNORED  = 2'd3;

   // item kinds
   localparam logic KIND_LOCATE  = 1'b0;
   localparam logic KIND_OBSERVE = 1'b1;

   // hash shifts
   localparam int HASH_SHIFT_A   = 3;
   localparam int HASH_SHIFT_B   = 11;
   localparam int HASH_SHIFT_COL = 5;

   localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

   // widest addresses the store can see (8 domains x 4096 sites x 8 targets)
   localparam int ENT_ADDR_W = 15;
   localparam int LST_ADDR_W = 18;
   localparam int DIST_W     = 4;

   typedef struct packed {
      logic              used;
      logic [63:0]       key_site;
      logic [31:0]       key_line;
      logic [31:0]       key_column;
      logic [31:0]       obs_count;
      logic [31:0]       stable;
      logic [31:0]       changes;
      logic [63:0]       last_target;
      logic [DIST_W-1:0] distinct;
      logic              mega;
   } entry_type;

   typedef struct packed {
      logic                  ent_rd;
      logic                  ent_wr;
      logic [ENT_ADDR_W-1:0] ent_addr;
      entry_type             ent_wdata;
      logic                  lst_rd;
      logic                  lst_wr;
      logic [LST_ADDR_W-1:0] lst_addr;
      logic [63:0]           lst_wdata;
   } store_req_type;

   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      return (v == CNT_MAX) ? v : v + 32'd1;
   endfunction

endpackage

`default_nettype wire

[src/call_site_target_profiler.sv]
// Call site target profiler: per-domain linear-probing site table with target profiling.
// A locate reduces the hash to a start slot, then reads and compares one entry per probe;
//   an observe reads its entry, compares tracked targets one at a time, then writes back.
// Throughput: one item at a time; req_stall stays high until the result enters the output
//   register, and a stalled output holds the sequencer in its result state.
// Reset: counters clear at once, then a sweep over all DOMAINS*SITES entries clears the entry memory.
`default_nettype none

module call_site_target_profiler #(
   parameter int SITES           = 64,
   parameter int DOMAINS         = 3,
   parameter int TRACKED_TARGETS = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_kind,
   input  wire logic [2:0]  req_domain,
   input  wire logic [63:0] req_site,
   input  wire logic [31:0] req_line,
   input  wire logic [31:0] req_column,
   input  wire logic [5:0]  req_slot,
   input  wire logic [63:0] req_target,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [5:0]       rsp_slot_index,
   output logic [31:0]      rsp_domain_total,
   output logic [31:0]      rsp_domain_dropped,
   output logic [31:0]      rsp_observations,
   output logic [31:0]      rsp_stable_count,
   output logic [31:0]      rsp_transition_count,
   output logic [2:0]       rsp_distinct_count,
   output logic             rsp_megamorphic
);

   localparam int ENTRIES = DOMAINS * SITES;
   localparam int LISTS   = ENTRIES * TRACKED_TARGETS;
   localparam int SLOT_W  = (SITES > 1) ? $clog2(SITES) : 1;
   localparam int PW      = $clog2(SITES + 1);
   localparam int EW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int LW      = (LISTS > 1) ? $clog2(LISTS) : 1;
   localparam int DW      = (DOMAINS > 1) ? $clog2(DOMAINS) : 1;
   localparam int DSW     = cstp_pkg::DIST_W;
   localparam logic [EW-1:0]  SITES_E = EW'(SITES);
   localparam logic [LW-1:0]  TT_L    = LW'(TRACKED_TARGETS);
   localparam logic [DSW-1:0] TT_D    = DSW'(TRACKED_TARGETS);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_HASH, S_PROBE_RD, S_PROBE_CMP,
      S_OBS_RD, S_OBS_ENT, S_LIST_RD, S_LIST_CMP, S_OBS_WR, S_RESULT
   } state_type;

   state_type           state_ff;
   logic [EW-1:0]       clr_ff;
   logic [2:0]          dom_ff;
   logic [63:0]         site_ff;
   logic [31:0]         line_ff;
   logic [31:0]         col_ff;
   logic [63:0]         target_ff;
   logic [SLOT_W-1:0]   s_ff;
   logic [PW-1:0]       probe_ff;
   logic [DSW-1:0]      li_ff;
   logic                hit_ff;
   cstp_pkg::entry_type ent_ff;
   logic [1:0]          status_ff;
   logic                show_dom_ff;
   logic                show_ent_ff;
   logic [31:0]         dom_total_ff [DOMAINS];
   logic [31:0]         dom_drop_ff  [DOMAINS];

   logic                rsp_valid_ff;
   logic [1:0]          rsp_status_ff;
   logic [5:0]          rsp_slot_ff;
   logic [31:0]         rsp_total_ff;
   logic [31:0]         rsp_dropped_ff;
   logic [31:0]         rsp_obs_ff;
   logic [31:0]         rsp_stable_ff;
   logic [31:0]         rsp_trans_ff;
   logic [2:0]          rsp_dist_ff;
   logic                rsp_mega_ff;

   logic                    req_accept;
   logic                    dom_ok;
   logic                    slot_ok;
   logic [63:0]             hash;
   logic                    mod_start;
   logic                    mod_done;
   logic [SLOT_W-1:0]       mod_rem;
   logic [EW-1:0]           ent_addr;
   logic [LW-1:0]           lst_base;
   cstp_pkg::store_req_type store_req;
   cstp_pkg::entry_type     rd_ent;
   logic [63:0]             rd_lst;
   logic                    keys_match;
   cstp_pkg::entry_type     ins_ent;
   cstp_pkg::entry_type     obs_ent;
   cstp_pkg::entry_type     upd_ent;
   logic                    add_target;
   logic [DSW-1:0]          li_next;
   logic                    out_free;

   // decode the incoming item
   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign dom_ok     = ({1'b0, req_domain} < 4'(DOMAINS));
   assign slot_ok    = ({7'd0, req_slot} < 13'(SITES));
   assign hash       = (req_site >> cstp_pkg::HASH_SHIFT_A)
                     ^ (req_site >> cstp_pkg::HASH_SHIFT_B)
                     ^ {32'd0, req_line}
                     ^ ({32'd0, req_column} << cstp_pkg::HASH_SHIFT_COL);
   assign mod_start  = req_accept && dom_ok && (req_kind == cstp_pkg::KIND_LOCATE);

   cstp_mod_unit #(
      .SITES (SITES)
   ) u_mod (
      .clock (clock),
      .reset (reset),
      .start (mod_start),
      .value (hash),
      .done  (mod_done),
      .rem   (mod_rem)
   );

   // entry and list addresses for the current domain and slot
   assign ent_addr = EW'(dom_ff) * SITES_E + EW'(s_ff);
   assign lst_base = LW'(ent_addr) * TT_L;

   // probe compare and claimed entry
   assign keys_match = (rd_ent.key_site == site_ff) && (rd_ent.key_line == line_ff)
                    && (rd_ent.key_column == col_ff);
   always_comb begin
      ins_ent            = rd_ent;
      ins_ent.used       = 1'b1;
      ins_ent.key_site   = site_ff;
      ins_ent.key_line   = line_ff;
      ins_ent.key_column = col_ff;
   end

   // counter update of an observed entry
   always_comb begin
      obs_ent = rd_ent;
      if (rd_ent.obs_count != 32'd0) begin
         if (rd_ent.last_target == target_ff) begin
            obs_ent.stable = cstp_pkg::sat_inc(rd_ent.stable);
         end else begin
            obs_ent.changes = cstp_pkg::sat_inc(rd_ent.changes);
         end
      end
      obs_ent.obs_count   = cstp_pkg::sat_inc(rd_ent.obs_count);
      obs_ent.last_target = target_ff;
   end

   // distinct target bookkeeping
   always_comb begin
      upd_ent    = ent_ff;
      add_target = 1'b0;
      if (!hit_ff) begin
         if (ent_ff.distinct < TT_D) begin
            add_target       = 1'b1;
            upd_ent.distinct = ent_ff.distinct + DSW'(1);
         end else begin
            upd_ent.distinct = TT_D + DSW'(1);
            upd_ent.mega     = 1'b1;
         end
      end
   end

   assign li_next  = li_ff + DSW'(1);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // memory requests per state
   always_comb begin
      store_req           = '0;
      store_req.ent_addr  = cstp_pkg::ENT_ADDR_W'(ent_addr);
      store_req.lst_addr  = cstp_pkg::LST_ADDR_W'(lst_base + LW'(li_ff));
      store_req.lst_wdata = target_ff;
      unique case (state_ff)
         S_CLEAR: begin
            store_req.ent_wr   = 1'b1;
            store_req.ent_addr = cstp_pkg::ENT_ADDR_W'(clr_ff);
         end
         S_PROBE_RD, S_OBS_RD: begin
            store_req.ent_rd = 1'b1;
         end
         S_PROBE_CMP: begin
            store_req.ent_wr    = !rd_ent.used;
            store_req.ent_wdata = ins_ent;
         end
         S_LIST_RD: begin
            store_req.lst_rd = 1'b1;
         end
         S_OBS_WR: begin
            store_req.ent_wr    = 1'b1;
            store_req.ent_wdata = upd_ent;
            store_req.lst_wr    = add_target;
            store_req.lst_addr  = cstp_pkg::LST_ADDR_W'(lst_base + LW'(ent_ff.distinct));
         end
         default: begin
         end
      endcase
   end

   cstp_store #(
      .SITES           (SITES),
      .DOMAINS         (DOMAINS),
      .TRACKED_TARGETS (TRACKED_TARGETS)
   ) u_store (
      .clock     (clock),
      .req       (store_req),
      .ent_rdata (rd_ent),
      .lst_rdata (rd_lst)
   );

   // sequencer, domain counters and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < DOMAINS; i++) begin
            dom_total_ff[i] <= '0;
            dom_drop_ff[i]  <= '0;
         end
      end else begin
         // drop a taken result unless the result state reloads it
         if (rsp_valid_ff && !rsp_stall && state_ff != S_RESULT) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + EW'(1);
               if (clr_ff == EW'(ENTRIES - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_accept) begin
                  dom_ff    <= req_domain;
                  site_ff   <= req_site;
                  line_ff   <= req_line;
                  col_ff    <= req_column;
                  target_ff <= req_target;
                  s_ff      <= SLOT_W'(req_slot);
                  probe_ff  <= '0;
                  hit_ff    <= 1'b0;
                  priority if (!dom_ok
                        || (req_kind == cstp_pkg::KIND_OBSERVE && !slot_ok)) begin
                     status_ff   <= cstp_pkg::ST_IGNORED;
                     show_dom_ff <= 1'b0;
                     show_ent_ff <= 1'b0;
                     state_ff    <= S_RESULT;
                  end else if (req_kind == cstp_pkg::KIND_OBSERVE) begin
                     status_ff   <= cstp_pkg::ST_FOUND;
                     show_dom_ff <= 1'b1;
                     show_ent_ff <= 1'b1;
                     state_ff    <= S_OBS_RD;
                  end else begin
                     dom_total_ff[req_domain[DW-1:0]] <=
                        cstp_pkg::sat_inc(dom_total_ff[req_domain[DW-1:0]]);
                     show_dom_ff <= 1'b1;
                     state_ff    <= S_HASH;
                  end
               end
            end
            S_HASH: begin
               if (mod_done) begin
                  s_ff     <= mod_rem;
                  state_ff <= S_PROBE_RD;
               end
            end
            S_PROBE_RD: begin
               state_ff <= S_PROBE_CMP;
            end
            S_PROBE_CMP: begin
               priority if (!rd_ent.used) begin
                  ent_ff      <= ins_ent;
                  status_ff   <= cstp_pkg::ST_INSERTED;
                  show_ent_ff <= 1'b1;
                  state_ff    <= S_RESULT;
               end else if (keys_match) begin
                  ent_ff      <= rd_ent;
                  status_ff   <= cstp_pkg::ST_FOUND;
                  show_ent_ff <= 1'b1;
                  state_ff    <= S_RESULT;
               end else if (probe_ff == PW'(SITES - 1)) begin
                  dom_drop_ff[dom_ff[DW-1:0]] <=
                     cstp_pkg::sat_inc(dom_drop_ff[dom_ff[DW-1:0]]);
                  status_ff   <= cstp_pkg::ST_DROPPED;
                  show_ent_ff <= 1'b0;
                  state_ff    <= S_RESULT;
               end else begin
                  probe_ff <= probe_ff + PW'(1);
                  s_ff     <= (s_ff == SLOT_W'(SITES - 1)) ? '0 : s_ff + SLOT_W'(1);
                  state_ff <= S_PROBE_RD;
               end
            end
            S_OBS_RD: begin
               state_ff <= S_OBS_ENT;
            end
            S_OBS_ENT: begin
               ent_ff <= obs_ent;
               li_ff  <= '0;
               if (rd_ent.distinct == '0) begin
                  state_ff <= S_OBS_WR;
               end else begin
                  state_ff <= S_LIST_RD;
               end
            end
            S_LIST_RD: begin
               state_ff <= S_LIST_CMP;
            end
            S_LIST_CMP: begin
               priority if (rd_lst == target_ff) begin
                  hit_ff   <= 1'b1;
                  state_ff <= S_OBS_WR;
               end else if (li_next < ent_ff.distinct && li_next < TT_D) begin
                  li_ff    <= li_next;
                  state_ff <= S_LIST_RD;
               end else begin
                  state_ff <= S_OBS_WR;
               end
            end
            S_OBS_WR: begin
               ent_ff   <= upd_ent;
               state_ff <= S_RESULT;
            end
            S_RESULT: begin
               if (out_free) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_status_ff  <= status_ff;
                  rsp_slot_ff    <= show_ent_ff ? 6'(s_ff) : 6'd0;
                  rsp_total_ff   <= show_dom_ff ? dom_total_ff[dom_ff[DW-1:0]] : 32'd0;
                  rsp_dropped_ff <= show_dom_ff ? dom_drop_ff[dom_ff[DW-1:0]] : 32'd0;
                  rsp_obs_ff     <= show_ent_ff ? ent_ff.obs_count : 32'd0;
                  rsp_stable_ff  <= show_ent_ff ? ent_ff.stable : 32'd0;
                  rsp_trans_ff   <= show_ent_ff ? ent_ff.changes : 32'd0;
                  rsp_dist_ff    <= show_ent_ff ? ent_ff.distinct[2:0] : 3'd0;
                  rsp_mega_ff    <= show_ent_ff && ent_ff.mega;
                  state_ff       <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_slot_index       = rsp_slot_ff;
   assign rsp_domain_total     = rsp_total_ff;
   assign rsp_domain_dropped   = rsp_dropped_ff;
   assign rsp_observations     = rsp_obs_ff;
   assign rsp_stable_count     = rsp_stable_ff;
   assign rsp_transition_count = rsp_trans_ff;
   assign rsp_distinct_count   = rsp_dist_ff;
   assign rsp_megamorphic      = rsp_mega_ff;

   // the remainder unit only finishes while the sequencer waits for it
   a_mod_done_in_hash: assert property (@(posedge clock) disable iff (reset)
      mod_done |-> state_ff == S_HASH)
      else $error("hash remainder finished outside hash wait");

   // a result leaves the result state into the output register
   a_result_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESULT && out_free) |=> (rsp_valid && state_ff == S_IDLE))
      else $error("result not loaded into output register");

   // the sweep never overlaps an item
   a_clear_stalls: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> req_stall)
      else $error("item accepted during clearing pass");

   // probing never runs past the table
   a_probe_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_PROBE_CMP |-> probe_ff < PW'(SITES))
      else $error("probe count beyond table size");

endmodule

`default_nettype wire

[src/cstp_mod_unit.sv]
// Start slot reduction: 64-bit hash modulo the site count.
// Byte-wise fold with a reciprocal quotient estimate, or a mask for a power of two.
// Does not use cstp_pkg.
`default_nettype none

module cstp_mod_unit #(
   parameter int SITES = 64
) (
   input  wire logic                                        clock,
   input  wire logic                                        reset,
   input  wire logic                                        start,
   input  wire logic [63:0]                                 value,
   output logic                                             done,
   output logic [((SITES > 1) ? $clog2(SITES) : 1)-1:0]     rem
);

   localparam int SLOT_W = (SITES > 1) ? $clog2(SITES) : 1;
   localparam bit POW2   = ((SITES & (SITES - 1)) == 0);

   logic              done_ff;
   logic [SLOT_W-1:0] rem_ff;

   assign done = done_ff;
   assign rem  = rem_ff;

   if (POW2) begin : g_mask
      // mask off the low bits into a registered remainder
      always_ff @(posedge clock) begin
         if (reset) begin
            done_ff <= 1'b0;
         end else begin
            done_ff <= start;
         end
         rem_ff <= SLOT_W'(value & 64'(SITES - 1));
      end
   end else begin : g_fold
      localparam int              AW      = SLOT_W + 8;
      localparam logic [31:0]     RECIP   = 32'((64'd1 << 32) / 64'(SITES));
      localparam logic [AW-1:0]   SITES_A = AW'(SITES);

      logic              busy_ff;
      logic [3:0]        cnt_ff;
      logic [63:0]       bits_ff;
      logic [AW-1:0]     acc;
      logic [AW+31:0]    prod;
      logic [AW-1:0]     quo;
      logic [AW-1:0]     rest;
      logic [SLOT_W-1:0] rem_in;

      // fold in the next byte: estimate the quotient, then subtract once if over
      always_comb begin
         acc  = {rem_ff, bits_ff[63:56]};
         prod = (AW+32)'(acc) * (AW+32)'(RECIP);
         quo  = prod[AW+31:32];
         rest = acc - AW'(quo * SITES_A);
         if (rest >= SITES_A) begin
            rem_in = SLOT_W'(rest - SITES_A);
         end else begin
            rem_in = SLOT_W'(rest);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b0;
            cnt_ff  <= '0;
         end else begin
            done_ff <= 1'b0;
            if (start) begin
               busy_ff <= 1'b1;
               cnt_ff  <= 4'd8;
               bits_ff <= value;
               rem_ff  <= '0;
            end else if (busy_ff) begin
               rem_ff  <= rem_in;
               bits_ff <= {bits_ff[55:0], 8'd0};
               cnt_ff  <= cnt_ff - 4'd1;
               if (cnt_ff == 4'd1) begin
                  busy_ff <= 1'b0;
                  done_ff <= 1'b1;
               end
            end
         end
      end
   end

endmodule

`default_nettype wire

[src/cstp_store.sv]
// Entry table and target list memories, one access port each.
// Read data registered; depends on cstp_pkg.
`default_nettype none

module cstp_store #(
   parameter int SITES           = 64,
   parameter int DOMAINS         = 3,
   parameter int TRACKED_TARGETS = 4
) (
   input  wire logic                    clock,
   input  wire cstp_pkg::store_req_type req,
   output cstp_pkg::entry_type          ent_rdata,
   output logic [63:0]                  lst_rdata
);

   localparam int ENTRIES = DOMAINS * SITES;
   localparam int LISTS   = ENTRIES * TRACKED_TARGETS;
   localparam int EW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int LW      = (LISTS > 1) ? $clog2(LISTS) : 1;

   cstp_pkg::entry_type entry_mem [ENTRIES];
   logic [63:0]         list_mem  [LISTS];
   cstp_pkg::entry_type ent_rd_ff;
   logic [63:0]         lst_rd_ff;

   assign ent_rdata = ent_rd_ff;
   assign lst_rdata = lst_rd_ff;

   // entry port
   always_ff @(posedge clock) begin
      if (req.ent_wr) begin
         entry_mem[req.ent_addr[EW-1:0]] <= req.ent_wdata;
      end
      if (req.ent_rd) begin
         ent_rd_ff <= entry_mem[req.ent_addr[EW-1:0]];
      end
   end

   // target list port
   always_ff @(posedge clock) begin
      if (req.lst_wr) begin
         list_mem[req.lst_addr[LW-1:0]] <= req.lst_wdata;
      end
      if (req.lst_rd) begin
         lst_rd_ff <= list_mem[req.lst_addr[LW-1:0]];
      end
   end

endmodule

`default_nettype wire
